### sv/nmea_rmc_sentence_generator_defines.svh
// Assertion macros for the sentence generator RTL, included by its top module.
`ifndef NMEA_RMC_SENTENCE_GENERATOR_DEFINES_SVH
`define NMEA_RMC_SENTENCE_GENERATOR_DEFINES_SVH

// Check that a condition holds at every clock edge outside reset.
`define NRMC_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define NRMC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the following cycle.
`define NRMC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/nmea_rmc_pkg.sv
// Types, constants and helper functions for the GPRMC sentence generator.
package nmea_rmc_pkg;

    localparam int SentenceLen = 73;
    localparam int DigitCount  = 14;
    localparam int BodyLast    = 67;

    typedef logic [5:0] t_pair_idx;
    typedef logic [6:0] t_byte_pos;

    localparam t_pair_idx LAST_PAIR = 6'd36;
    localparam t_byte_pos HEX_HI_POS = 7'd69;
    localparam t_byte_pos HEX_LO_POS = 7'd70;

    localparam logic [1:0] CHARS_PAIR = 2'd2;
    localparam logic [1:0] CHARS_LAST = 2'd1;

    // Sentence text with '0' in every time, date and checksum slot
    localparam logic [8*SentenceLen-1:0] TEMPLATE =
        "$GPRMC,000000.00,A,2812.0498,N,11313.1361,E,0.0,180.0,000000,3.9,W,A*00\r\n";

    // Positions of the decimal digits: hhmmss, cc, ddmmyy
    localparam logic [DigitCount-1:0][6:0] DIGIT_POS = {
        7'd59, 7'd58, 7'd57, 7'd56, 7'd55, 7'd54,
        7'd15, 7'd14,
        7'd12, 7'd11, 7'd10, 7'd9, 7'd8, 7'd7
    };

    // Digits of one sentence and the checksum over its body
    typedef struct packed {
        logic [DigitCount-1:0][3:0] digit;
        logic [7:0]                 sum;
    } t_sentence;

    function automatic logic [7:0] tmpl_byte(input t_byte_pos pos);
        logic [7:0] b;
        b = 8'h00;
        if (pos < 7'(SentenceLen)) begin
            b = TEMPLATE[8*(SentenceLen-1-int'(pos)) +: 8];
        end
        return b;
    endfunction

    // XOR of the fixed body text; the fourteen '0' placeholders cancel out
    function automatic logic [7:0] body_xor();
        logic [7:0] s;
        s = 8'h00;
        for (int i = 1; i <= BodyLast; i++) begin
            s = s ^ TEMPLATE[8*(SentenceLen-1-i) +: 8];
        end
        return s;
    endfunction

    localparam logic [7:0] BODY_SUM = body_xor();

    // Two low decimal digits {tens, ones} of a value up to 127
    function automatic logic [7:0] two_digits(input logic [6:0] v);
        logic [6:0]  r;
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  ones;
        r    = (v >= 7'd100) ? 7'(v - 7'd100) : v;
        prod = 15'(r) * 15'd205;
        tens = prod[14:11];
        ones = 7'(r - 7'(tens) * 7'd10);
        return {tens, ones[3:0]};
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        return (n < 4'd10) ? (8'h30 + 8'(n)) : (8'h37 + 8'(n));
    endfunction

    // Byte of the finished sentence at a given position
    function automatic logic [7:0] sentence_byte(input t_byte_pos pos, input t_sentence s);
        logic [7:0] b;
        b = tmpl_byte(pos);
        for (int i = 0; i < DigitCount; i++) begin
            if (pos == DIGIT_POS[i]) begin
                b = {4'h3, s.digit[i]};
            end
        end
        if (pos == HEX_HI_POS) begin
            b = hex_char(s.sum[7:4]);
        end
        if (pos == HEX_LO_POS) begin
            b = hex_char(s.sum[3:0]);
        end
        return b;
    endfunction

endpackage

### sv/nmea_rmc_sentence_generator.sv
// A rising edge of the pulse-per-second input (tuser set) produces one 73-byte GPRMC
// sentence with the given UTC time and date, sent as 37 output transactions of two
// bytes each; the last carries the LF byte alone and raises tlast. An item with tuser
// clear gives nothing. The pair sequencer sends one transaction per cycle while the
// sink is ready; an input register holds one further item while a sentence is sent,
// and the next sentence follows the last pair without a gap.
module nmea_rmc_sentence_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // hour[4:0], minute[10:5], second[16:11], centisecond[23:17],
    // day_of_month[28:24], month[32:29], year_in_century[39:33]
    input  logic [39:0] i_s_axis_tdata,
    // edge_level[0]
    input  logic [0:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // first_char[7:0], second_char[15:8], char_count[17:16], zero[23:18]
    output logic [23:0] o_m_axis_tdata,
    output logic        o_m_axis_tlast
);
    import nmea_rmc_pkg::*;

    `include "nmea_rmc_sentence_generator_defines.svh"

    logic        r_in_valid;
    logic [39:0] r_in_data;
    logic        in_acc;
    logic        take;
    t_sentence   sentence;

    assign o_s_axis_tready = !r_in_valid || take;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;

    // Capture rising-edge items; drop falling-edge ones
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_acc) begin
            r_in_valid <= i_s_axis_tuser[0];
        end else if (take) begin
            r_in_valid <= 1'b0;
        end
        if (in_acc) begin
            r_in_data <= i_s_axis_tdata;
        end
    end

    nmea_rmc_fmt u_fmt (
        .i_hour            (r_in_data[4:0]),
        .i_minute          (r_in_data[10:5]),
        .i_second          (r_in_data[16:11]),
        .i_centisecond     (r_in_data[23:17]),
        .i_day_of_month    (r_in_data[28:24]),
        .i_month           (r_in_data[32:29]),
        .i_year_in_century (r_in_data[39:33]),
        .o_sentence        (sentence)
    );

    nmea_rmc_emit u_emit (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (r_in_valid),
        .i_sentence      (sentence),
        .o_take          (take),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    `NRMC_ASSERT_SAME(a_last_pair, (o_m_axis_tvalid && o_m_axis_tlast), (o_m_axis_tdata[7:0] == 8'h0A && o_m_axis_tdata[15:8] == 8'h00 && o_m_axis_tdata[17:16] == CHARS_LAST), "last transaction must carry LF alone")
    `NRMC_ASSERT_SAME(a_full_pair, (o_m_axis_tvalid && !o_m_axis_tlast), (o_m_axis_tdata[17:16] == CHARS_PAIR), "inner transaction must carry two bytes")
    `NRMC_ASSERT_NEXT(a_hold_item, (r_in_valid && !o_s_axis_tready), r_in_valid, "pending item lost")
    `NRMC_ASSERT_ALWAYS(a_take_pending, (!take || r_in_valid), "sentence taken without a pending item")

endmodule

### sv/nmea_rmc_fmt.sv
// Time and date to decimal digits, plus the sentence checksum.
module nmea_rmc_fmt (
    input  logic [4:0]              i_hour,
    input  logic [5:0]              i_minute,
    input  logic [5:0]              i_second,
    input  logic [6:0]              i_centisecond,
    input  logic [4:0]              i_day_of_month,
    input  logic [3:0]              i_month,
    input  logic [6:0]              i_year_in_century,
    output nmea_rmc_pkg::t_sentence o_sentence
);
    import nmea_rmc_pkg::*;

    logic [6:0][7:0] pairs;
    logic [3:0]      dig_xor;

    // Split each field into two digits
    assign pairs[0] = two_digits(7'(i_hour));
    assign pairs[1] = two_digits(7'(i_minute));
    assign pairs[2] = two_digits(7'(i_second));
    assign pairs[3] = two_digits(i_centisecond);
    assign pairs[4] = two_digits(7'(i_day_of_month));
    assign pairs[5] = two_digits(7'(i_month));
    assign pairs[6] = two_digits(i_year_in_century);

    // Fold the digits into the checksum; their '3' high nibbles cancel in pairs
    always_comb begin
        dig_xor = 4'h0;
        for (int k = 0; k < 7; k++) begin
            o_sentence.digit[2*k]   = pairs[k][7:4];
            o_sentence.digit[2*k+1] = pairs[k][3:0];
            dig_xor = dig_xor ^ pairs[k][7:4] ^ pairs[k][3:0];
        end
        o_sentence.sum = {BODY_SUM[7:4], BODY_SUM[3:0] ^ dig_xor};
    end

endmodule

### sv/nmea_rmc_emit.sv
// Sentence register, pair sequencer and output register.
module nmea_rmc_emit (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  nmea_rmc_pkg::t_sentence i_sentence,
    output logic                    o_take,
    output logic                    o_m_axis_tvalid,
    input  logic                    i_m_axis_tready,
    output logic [23:0]             o_m_axis_tdata,
    output logic                    o_m_axis_tlast
);
    import nmea_rmc_pkg::*;

    logic       r_busy, n_busy;
    t_pair_idx  r_pair, n_pair;
    t_sentence  r_sent;
    logic       r_out_valid;
    logic [7:0] r_first, r_second;
    logic [1:0] r_count;
    logic       r_last;

    logic       adv;
    logic       last_adv;
    logic       is_last;
    t_byte_pos  pos_a;
    logic [7:0] byte_a, byte_b;

    // Advance a pair when the output register is free
    assign adv      = r_busy && (!r_out_valid || i_m_axis_tready);
    assign is_last  = (r_pair == LAST_PAIR);
    assign last_adv = adv && is_last;
    assign o_take   = i_valid && (!r_busy || last_adv);

    assign pos_a  = {r_pair, 1'b0};
    assign byte_a = sentence_byte(pos_a, r_sent);
    assign byte_b = is_last ? 8'h00 : sentence_byte(7'(pos_a + 7'd1), r_sent);

    always_comb begin
        n_busy = r_busy;
        n_pair = r_pair;
        if (o_take) begin
            n_busy = 1'b1;
            n_pair = '0;
        end else if (last_adv) begin
            n_busy = 1'b0;
        end else if (adv) begin
            n_pair = 6'(r_pair + 6'd1);
        end
    end

    // Hold the sentence and step through its pairs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pair <= '0;
        end else begin
            r_busy <= n_busy;
            r_pair <= n_pair;
        end
        if (o_take) begin
            r_sent <= i_sentence;
        end
    end

    // Load the output register; drop valid once the transaction completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (adv) begin
            r_first  <= byte_a;
            r_second <= byte_b;
            r_count  <= is_last ? CHARS_LAST : CHARS_PAIR;
            r_last   <= is_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'b0, r_count, r_second, r_first};
    assign o_m_axis_tlast  = r_last;

endmodule

### bench/testbench.sv
// Self-checking testbench for the GPRMC sentence generator.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import nmea_rmc_pkg::CHARS_PAIR;
    import nmea_rmc_pkg::CHARS_LAST;

    localparam int PAIRS_PER_SENTENCE = 37;
    localparam int IDLE_PERCENT       = 34;
    localparam int DRAIN_CYCLES       = 50;

    // One time stamp as delivered after a pulse edge
    typedef struct {
        logic       rising;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [6:0] centisec;
        logic [4:0] day;
        logic [3:0] month;
        logic [6:0] year;
    } t_pps_stamp;

    // One outgoing transaction of the sentence stream
    typedef struct {
        logic [7:0] first_char;
        logic [7:0] second_char;
        logic [1:0] char_count;
        logic       last;
    } t_char_pair;

    logic        i_clk;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    // hour, minute, second, centisecond, day_of_month, month, year_in_century
    logic [39:0] i_s_axis_tdata  = '0;
    // edge_level
    logic [0:0]  i_s_axis_tuser  = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    // first_char, second_char, char_count, zero padding
    logic [23:0] o_m_axis_tdata;
    logic        o_m_axis_tlast;

    t_char_pair  pair_q[$];
    int unsigned mismatch_count = 0;
    bit          no_idle        = 1'b0;

    nmea_rmc_sentence_generator dut (.*);

    // Free-running clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop well beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("testbench: done, errors");
        $finish;
    end

    // Stall the sink at random unless a clean stretch is running
    always @(negedge i_clk) begin
        i_m_axis_tready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic string two_dec(input int unsigned v);
        return $sformatf("%02d", v % 100);
    endfunction

    function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
        return (nib < 4'd10) ? 8'("0") + 8'(nib) : 8'("A") + 8'(nib) - 8'd10;
    endfunction

    // Build the sentence for a rising edge and queue its character pairs
    function automatic void queue_sentence(input t_pps_stamp st);
        string      body;
        logic [7:0] line[$];
        logic [7:0] sum;
        t_char_pair p;
        if (!st.rising) return;
        body = {"$GPRMC,", two_dec(st.hour), two_dec(st.minute), two_dec(st.second), ".",
                two_dec(st.centisec), ",A,2812.0498,N,11313.1361,E,0.0,180.0,",
                two_dec(st.day), two_dec(st.month), two_dec(st.year), ",3.9,W,A"};
        sum = 8'h00;
        for (int i = 0; i < body.len(); i++) begin
            line.push_back(body[i]);
            if (i > 0) sum ^= body[i];
        end
        line.push_back("*");
        line.push_back(hex_ascii(sum[7:4]));
        line.push_back(hex_ascii(sum[3:0]));
        line.push_back(8'h0D);
        line.push_back(8'h0A);
        for (int k = 0; k < PAIRS_PER_SENTENCE; k++) begin
            p.last        = (k == PAIRS_PER_SENTENCE - 1);
            p.first_char  = line[2*k];
            p.second_char = p.last ? 8'h00 : line[2*k+1];
            p.char_count  = p.last ? CHARS_LAST : CHARS_PAIR;
            pair_q.push_back(p);
        end
    endfunction

    function automatic t_pps_stamp make_stamp(input logic rising, input int h, input int mi,
                                              input int s, input int c, input int d,
                                              input int mo, input int y);
        t_pps_stamp st;
        st.rising   = rising;
        st.hour     = 5'(h);
        st.minute   = 6'(mi);
        st.second   = 6'(s);
        st.centisec = 7'(c);
        st.day      = 5'(d);
        st.month    = 4'(mo);
        st.year     = 7'(y);
        return st;
    endfunction

    // Either a plausible calendar stamp or any value the fields can hold
    function automatic t_pps_stamp random_stamp(input logic rising);
        if ($urandom_range(1))
            return make_stamp(rising, $urandom_range(23), $urandom_range(59),
                              $urandom_range(60), $urandom_range(99), $urandom_range(31, 1),
                              $urandom_range(12, 1), $urandom_range(99));
        return make_stamp(rising, $urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom);
    endfunction

    // Offer one stamp, hold it until the transaction completes, then predict
    task automatic send_stamp(input t_pps_stamp st);
        while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
            @(negedge i_clk);
            i_s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= st.rising;
        i_s_axis_tdata  <= {st.year, st.month, st.day, st.centisec, st.second,
                            st.minute, st.hour};
        do @(posedge i_clk); while (!o_s_axis_tready);
        queue_sentence(st);
    endtask

    // Compare each output transaction with the oldest expected pair
    always @(posedge i_clk) begin
        t_char_pair exp_pair;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pair_q.size() == 0) begin
                report_mismatch($sformatf("unexpected transaction, tdata %h", o_m_axis_tdata));
            end else begin
                exp_pair = pair_q.pop_front();
                if (o_m_axis_tdata[7:0] !== exp_pair.first_char)
                    report_mismatch($sformatf("first_char %h, expected %h",
                                              o_m_axis_tdata[7:0], exp_pair.first_char));
                if (o_m_axis_tdata[15:8] !== exp_pair.second_char)
                    report_mismatch($sformatf("second_char %h, expected %h",
                                              o_m_axis_tdata[15:8], exp_pair.second_char));
                if (o_m_axis_tdata[17:16] !== exp_pair.char_count)
                    report_mismatch($sformatf("char_count %0d, expected %0d",
                                              o_m_axis_tdata[17:16], exp_pair.char_count));
                if (o_m_axis_tlast !== exp_pair.last)
                    report_mismatch($sformatf("tlast %b, expected %b",
                                              o_m_axis_tlast, exp_pair.last));
            end
        end
    end

    // Field extremes, values above 99 and calendar values out of range
    task automatic test_field_extremes();
        send_stamp(make_stamp(1'b1, 0, 0, 0, 0, 0, 0, 0));
        send_stamp(make_stamp(1'b1, 31, 63, 63, 127, 31, 15, 127));
        send_stamp(make_stamp(1'b1, 23, 59, 60, 99, 31, 12, 99));
        send_stamp(make_stamp(1'b1, 0, 0, 0, 100, 1, 1, 100));
        send_stamp(make_stamp(1'b1, 24, 60, 61, 110, 0, 13, 119));
        send_stamp(make_stamp(1'b1, 21, 42, 21, 85, 10, 5, 42));
        send_stamp(make_stamp(1'b1, 10, 21, 42, 42, 21, 10, 85));
        send_stamp(make_stamp(1'b1, 12, 34, 56, 78, 9, 4, 25));
    endtask

    // Falling edges must produce nothing, also between rising edges
    task automatic test_falling_edges();
        send_stamp(make_stamp(1'b0, 31, 63, 63, 127, 31, 15, 127));
        send_stamp(random_stamp(1'b1));
        send_stamp(random_stamp(1'b0));
        send_stamp(random_stamp(1'b0));
        send_stamp(random_stamp(1'b1));
        send_stamp(random_stamp(1'b0));
    endtask

    // Long stretch with neither side idling: sentences back to back
    task automatic test_back_to_back();
        no_idle = 1'b1;
        repeat (40) send_stamp(random_stamp(1'b1));
        no_idle = 1'b0;
    endtask

    // Mostly rising edges with random content, falling edges as noise
    task automatic test_random_stamps();
        int sentences;
        sentences = 0;
        while (sentences < 300) begin
            if ($urandom_range(99) < 15) begin
                send_stamp(random_stamp(1'b0));
            end else begin
                send_stamp(random_stamp(1'b1));
                sentences++;
            end
        end
    endtask

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_field_extremes();
        test_falling_edges();
        test_back_to_back();
        test_random_stamps();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (pair_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

### sim.f
+incdir+sv
sv/nmea_rmc_pkg.sv
sv/nmea_rmc_fmt.sv
sv/nmea_rmc_emit.sv
sv/nmea_rmc_sentence_generator.sv
bench/testbench.sv
